/* rtl/core/gcode_line_word_parser_macros.svh */
// assertion macros for the g-code line word parser checker
`ifndef GCODE_LINE_WORD_PARSER_MACROS_SVH
`define GCODE_LINE_WORD_PARSER_MACROS_SVH

// general property, clocked on clk and off while in reset
`define GLP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// signal holds on the cycle after cond
`define GLP_ASSERT_HOLD(lbl, cond, sig, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> $stable(sig)) \
    else $error(msg);

`endif

/* rtl/core/glp_pkg.sv */
// shared types, constants and helpers of the g-code line word parser
package glp_pkg;

  localparam int FRACTION_DIGITS = 3;
  localparam int VALUE_WIDTH     = 32;
  localparam int NUM_AXES        = 4;
  localparam int CHAR_W          = 8;
  localparam int ACC_W           = VALUE_WIDTH - 1;
  localparam int FC_W            = $clog2(FRACTION_DIGITS + 1);
  localparam int POW_W           = 24;
  localparam int SUM_W           = VALUE_WIDTH + POW_W;
  localparam int OUT_BITS        = 4 + NUM_AXES * VALUE_WIDTH;
  localparam int OUT_W           = ((OUT_BITS + 7) / 8) * 8;

  // output word layout
  localparam int OUT_ST_LSB   = 0;
  localparam int OUT_MODE_BIT = 3;
  localparam int OUT_VAL_LSB  = 4;

  localparam logic [ACC_W-1:0] ACC_MAX = '1;

  typedef logic [CHAR_W-1:0]             char_t;
  typedef logic [2:0]                    status_t;
  typedef logic [1:0]                    axis_t;
  typedef logic signed [VALUE_WIDTH-1:0] value_t;
  typedef value_t [NUM_AXES-1:0]         value_set_t;

  localparam status_t ST_UNDEF = 3'd0;
  localparam status_t ST_OK    = 3'd1;
  localparam status_t ST_G_ERR = 3'd2;
  localparam status_t ST_X_ERR = 3'd3;

  localparam axis_t AX_X = 2'd0;
  localparam axis_t AX_Y = 2'd1;
  localparam axis_t AX_Z = 2'd2;
  localparam axis_t AX_F = 2'd3;

  localparam char_t CH_NUL    = 8'h00;
  localparam char_t CH_SPACE  = 8'h20;
  localparam char_t CH_LPAREN = 8'h28;
  localparam char_t CH_MINUS  = 8'h2D;
  localparam char_t CH_DOT    = 8'h2E;
  localparam char_t CH_0      = 8'h30;
  localparam char_t CH_9      = 8'h39;
  localparam char_t CH_F      = 8'h46;
  localparam char_t CH_G      = 8'h47;
  localparam char_t CH_X      = 8'h58;
  localparam char_t CH_Y      = 8'h59;
  localparam char_t CH_Z      = 8'h5A;
  localparam char_t CH_LO_A   = 8'h61;
  localparam char_t CH_LO_Z   = 8'h7A;
  localparam char_t CH_CASE   = 8'h20;

  typedef enum logic [3:0] {
    PH_START   = 4'd0,
    PH_MAIN    = 4'd1,
    PH_G9      = 4'd2,
    PH_G0      = 4'd3,
    PH_NSPACE  = 4'd4,
    PH_NFIRST  = 4'd5,
    PH_NDIGITS = 4'd6,
    PH_IGNORE  = 4'd7
  } phase_t;

  typedef struct packed {
    phase_t           phase;
    axis_t            axis_sel;
    logic             negative;
    logic             in_fraction;
    logic [FC_W-1:0]  frac_cnt;
    logic [ACC_W-1:0] acc;
    status_t          line_status;
    logic             mode;
  } glp_state_t;

  localparam glp_state_t STATE_INIT = '{
    phase:       PH_START,
    axis_sel:    AX_X,
    negative:    1'b0,
    in_fraction: 1'b0,
    frac_cnt:    '0,
    acc:         '0,
    line_status: ST_UNDEF,
    mode:        1'b0
  };

  function automatic logic [POW_W-1:0] pow_ten(input int n);
    logic [POW_W-1:0] p;
    p = POW_W'(1);
    for (int i = 0; i < n; i++) begin
      p = POW_W'(p * 10);
    end
    return p;
  endfunction

endpackage

/* rtl/core/glp_step.sv */
// per-character next-state logic of the g-code line word parser
module glp_step import glp_pkg::*; (
  input  glp_state_t st,
  input  value_set_t vals,
  input  char_t      ch,
  input  logic       eol,
  output glp_state_t st_nxt,
  output value_set_t vals_nxt,
  output logic       emit
);

  typedef struct packed {
    phase_t  phase;
    logic    set_ok;
    logic    err_en;
    status_t err_code;
    logic    start_num;
    logic    do_digit;
    logic    set_frac;
    logic    set_neg;
    logic    commit;
    logic    set_mode;
  } glp_ctl_t;

  glp_ctl_t         ctl;
  char_t            ch_up;
  logic             is_digit;
  logic             word_g;
  logic             word_hit;
  axis_t            word_sel;
  logic             fin;
  logic [3:0]       dig;
  logic [POW_W-1:0] frac_w;
  logic             frac_room;
  logic [SUM_W-1:0] int_sum;
  logic [SUM_W-1:0] frac_sum;
  logic [SUM_W-1:0] dig_sum;
  logic [ACC_W-1:0] acc_dig;
  logic [ACC_W-1:0] acc1;
  logic             neg1;
  axis_t            sel1;

  function automatic value_t to_value(input logic [ACC_W-1:0] a, input logic neg);
    value_t v;
    v = value_t'({1'b0, a});
    return neg ? -v : v;
  endfunction

  assign ch_up    = (ch >= CH_LO_A && ch <= CH_LO_Z) ? char_t'(ch - CH_CASE) : ch;
  assign is_digit = (ch >= CH_0) && (ch <= CH_9);
  assign word_g   = (ch_up == CH_G);
  assign fin      = eol || (ch == CH_NUL);
  assign emit     = fin;
  assign dig      = ch[3:0];

  always_comb begin
    word_hit = 1'b1;
    word_sel = AX_X;
    case (ch_up)
      CH_X:    word_sel = AX_X;
      CH_Y:    word_sel = AX_Y;
      CH_Z:    word_sel = AX_Z;
      CH_F:    word_sel = AX_F;
      default: word_hit = 1'b0;
    endcase
  end

  // phase and control decisions
  always_comb begin
    ctl          = '0;
    ctl.phase    = st.phase;
    ctl.err_code = ST_G_ERR;
    case (st.phase)
      PH_START: begin
        ctl.set_ok = 1'b1;
        if (ch == CH_LPAREN) begin
          ctl.phase = PH_IGNORE;
        end else if (word_g) begin
          ctl.phase = PH_G9;
        end else if (ch != CH_SPACE) begin
          ctl.phase = PH_MAIN;
          if (word_hit) begin
            ctl.start_num = 1'b1;
            ctl.phase     = PH_NSPACE;
          end
        end
      end
      PH_MAIN: begin
        if (word_g) begin
          ctl.err_en = 1'b1;
          ctl.phase  = PH_IGNORE;
        end else if (word_hit) begin
          ctl.start_num = 1'b1;
          ctl.phase     = PH_NSPACE;
        end
      end
      PH_G9: begin
        if (ch == CH_9) begin
          ctl.phase = PH_G0;
        end else begin
          ctl.err_en = 1'b1;
          ctl.phase  = PH_IGNORE;
        end
      end
      PH_G0: begin
        if (ch == CH_0) begin
          ctl.set_mode = 1'b1;
          ctl.phase    = PH_MAIN;
        end else begin
          ctl.err_en = 1'b1;
          ctl.phase  = PH_IGNORE;
        end
      end
      PH_NSPACE, PH_NFIRST: begin
        if (st.phase == PH_NSPACE && ch == CH_SPACE) begin
          ctl.phase = PH_NSPACE;
        end else if (st.phase == PH_NSPACE && ch == CH_MINUS) begin
          ctl.set_neg = 1'b1;
          ctl.phase   = PH_NFIRST;
        end else if (is_digit) begin
          ctl.do_digit = 1'b1;
          ctl.phase    = PH_NDIGITS;
        end else begin
          ctl.err_en   = 1'b1;
          ctl.err_code = status_t'(ST_X_ERR + {1'b0, st.axis_sel});
          ctl.phase    = PH_IGNORE;
        end
      end
      PH_NDIGITS: begin
        if (is_digit) begin
          ctl.do_digit = 1'b1;
        end else if (ch == CH_DOT) begin
          ctl.set_frac = 1'b1;
        end else begin
          ctl.commit = 1'b1;
          ctl.phase  = PH_MAIN;
          if (word_g) begin
            ctl.err_en = 1'b1;
            ctl.phase  = PH_IGNORE;
          end else if (word_hit) begin
            ctl.start_num = 1'b1;
            ctl.phase     = PH_NSPACE;
          end
        end
      end
      default: begin
        ctl.phase = st.phase;
      end
    endcase
  end

  // digit arithmetic
  always_comb begin
    frac_w = '0;
    for (int k = 0; k < FRACTION_DIGITS; k++) begin
      if (st.frac_cnt == FC_W'(k)) begin
        frac_w = pow_ten(FRACTION_DIGITS - 1 - k);
      end
    end
    frac_room = (st.frac_cnt < FC_W'(FRACTION_DIGITS));
    int_sum   = SUM_W'({st.acc, 3'b000}) + SUM_W'({st.acc, 1'b0})
              + SUM_W'(POW_W'(dig) * pow_ten(FRACTION_DIGITS));
    frac_sum  = SUM_W'(st.acc) + SUM_W'(POW_W'(dig) * frac_w);
    if (!st.in_fraction) begin
      dig_sum = int_sum;
    end else if (frac_room) begin
      dig_sum = frac_sum;
    end else begin
      dig_sum = SUM_W'(st.acc);
    end
    acc_dig = (dig_sum > SUM_W'(ACC_MAX)) ? ACC_MAX : dig_sum[ACC_W-1:0];
  end

  // state and value updates
  always_comb begin
    sel1 = ctl.start_num ? word_sel : st.axis_sel;
    acc1 = ctl.start_num ? '0 : (ctl.do_digit ? acc_dig : st.acc);
    neg1 = ctl.start_num ? 1'b0 : (st.negative | ctl.set_neg);

    st_nxt          = st;
    st_nxt.phase    = ctl.phase;
    st_nxt.axis_sel = sel1;
    st_nxt.acc      = acc1;
    st_nxt.negative = neg1;
    st_nxt.mode     = st.mode | ctl.set_mode;
    if (ctl.start_num) begin
      st_nxt.in_fraction = 1'b0;
      st_nxt.frac_cnt    = '0;
    end else begin
      st_nxt.in_fraction = st.in_fraction | ctl.set_frac;
      if (ctl.do_digit && st.in_fraction && frac_room) begin
        st_nxt.frac_cnt = FC_W'(st.frac_cnt + 1'b1);
      end
    end
    if (ctl.err_en) begin
      st_nxt.line_status = ctl.err_code;
    end else if (ctl.set_ok) begin
      st_nxt.line_status = ST_OK;
    end

    vals_nxt = vals;
    if (ctl.commit) begin
      vals_nxt[st.axis_sel] = to_value(st.acc, st.negative);
    end

    // end of line
    if (fin) begin
      case (ctl.phase)
        PH_START: st_nxt.line_status = ST_OK;
        PH_NSPACE, PH_NFIRST, PH_NDIGITS: vals_nxt[sel1] = to_value(acc1, neg1);
        PH_G9, PH_G0: st_nxt.line_status = ST_G_ERR;
        default: st_nxt.line_status = st_nxt.line_status;
      endcase
      st_nxt.phase       = PH_START;
      st_nxt.negative    = 1'b0;
      st_nxt.in_fraction = 1'b0;
      st_nxt.frac_cnt    = '0;
      st_nxt.acc         = '0;
    end
  end

endmodule

/* rtl/core/gcode_line_word_parser.sv */
// top level of the g-code line word parser
//
//   channel  dir  handshake           payload
//   in_      in   tvalid/tready       tdata: char_code, tuser: command, tlast: end_of_line
//   out_     out  tvalid/tready       tdata: status, mode_code, x, y, z, feed values
//
// one item per cycle while in_tready is high: each character updates the parse state in the cycle it is taken
// a result is shown in the cycle after the item that ends the line is taken
// in_tready drops only while the output register holds a result not yet taken
// rst_n (synchronous) returns the parse state, values, mode and status to zero
module gcode_line_word_parser import glp_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [CHAR_W-1:0] in_tdata,   // [7:0] char_code
  input  logic              in_tuser,   // [0] command
  input  logic              in_tlast,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [OUT_W-1:0]  out_tdata   // status, mode_code, x, y, z, feed_value, zero pad
);

  glp_state_t       state_r;
  glp_state_t       state_nxt;
  value_set_t       vals_r;
  value_set_t       vals_nxt;
  logic             emit;
  logic             accept;
  logic             out_valid_r;
  logic             out_valid_nxt;
  logic [OUT_W-1:0] out_data_r;
  logic [OUT_W-1:0] out_data_nxt;

  glp_step u_step (
    .st       (state_r),
    .vals     (vals_r),
    .ch       (in_tdata),
    .eol      (in_tlast),
    .st_nxt   (state_nxt),
    .vals_nxt (vals_nxt),
    .emit     (emit)
  );

  assign in_tready  = !out_valid_r || out_tready;
  assign accept     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_comb begin
    out_data_nxt = '0;
    out_data_nxt[OUT_ST_LSB +: 3] = state_nxt.line_status;
    out_data_nxt[OUT_MODE_BIT]    = state_nxt.mode;
    for (int a = 0; a < NUM_AXES; a++) begin
      out_data_nxt[OUT_VAL_LSB + a * VALUE_WIDTH +: VALUE_WIDTH] = vals_nxt[a];
    end
    if (accept && !in_tuser && emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= STATE_INIT;
      vals_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (accept) begin
        if (in_tuser) begin
          state_r <= STATE_INIT;
          vals_r  <= '0;
        end else begin
          state_r <= state_nxt;
          vals_r  <= vals_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !in_tuser && emit) begin
      out_data_r <= out_data_nxt;
    end
  end

endmodule

/* rtl/core/glp_checker.sv */
// port checker of the g-code line word parser and its bind
`include "gcode_line_word_parser_macros.svh"

module glp_checker import glp_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_tvalid,
  input logic              in_tready,
  input logic [CHAR_W-1:0] in_tdata,
  input logic              in_tuser,
  input logic              in_tlast,
  input logic              out_tvalid,
  input logic              out_tready,
  input logic [OUT_W-1:0]  out_tdata
);

  logic in_acc;
  logic line_end;

  assign in_acc   = in_tvalid && in_tready;
  assign line_end = in_tlast || (in_tdata == CH_NUL);

  `GLP_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid, "result dropped while stalled")
  `GLP_ASSERT_HOLD(a_out_stable, out_tvalid && !out_tready, out_tdata, "result changed while stalled")
  `GLP_ASSERT(a_line_result, in_acc && !in_tuser && line_end |=> out_tvalid, "line end gave no result")
  `GLP_ASSERT(a_clear_quiet, in_acc && in_tuser |=> !out_tvalid, "clear item gave a result")
  `GLP_ASSERT(a_status_code, out_tvalid |-> out_tdata[2:0] != 3'd7, "status code out of range")

endmodule

bind gcode_line_word_parser glp_checker u_glp_checker (.*);

/* tb/gcode_line_word_parser_checker.sv */
`timescale 1ns / 100ps
// checker for the g-code line word parser: predicts each line result and compares it
module gcode_line_word_parser_checker import glp_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  input  logic             in_tready,
  input  char_t            in_tdata,
  input  logic             in_tuser,
  input  logic             in_tlast,
  input  logic             out_tvalid,
  input  logic             out_tready,
  input  logic [OUT_W-1:0] out_tdata,
  output int               lines_due,
  output int               mismatches
);

  localparam logic [63:0] MAG_LIMIT = (64'd1 << (VALUE_WIDTH - 1)) - 64'd1;

  typedef struct packed {
    status_t st;
    logic    mode;
    value_t  x;
    value_t  y;
    value_t  z;
    value_t  feed;
  } line_result_t;

  line_result_t line_results_due[$];
  line_result_t want_res;

  phase_t      phase;
  axis_t       sel;
  logic        neg;
  logic        in_frac;
  int          frac_cnt;
  logic [63:0] acc;
  status_t     line_st;
  logic        mode;
  value_t      vals[NUM_AXES];

  initial begin
    mismatches = 0;
    lines_due = 0;
  end

  function automatic logic [63:0] decade(int n);
    logic [63:0] p;
    p = 64'd1;
    for (int i = 0; i < n; i++) begin
      p = p * 64'd10;
    end
    return p;
  endfunction

  function automatic void parser_reset();
    phase = PH_START;
    sel = AX_X;
    neg = 1'b0;
    in_frac = 1'b0;
    frac_cnt = 0;
    acc = '0;
    line_st = ST_UNDEF;
    mode = 1'b0;
    for (int i = 0; i < NUM_AXES; i++) begin
      vals[i] = '0;
    end
  endfunction

  function automatic void begin_number(axis_t a);
    sel = a;
    neg = 1'b0;
    in_frac = 1'b0;
    frac_cnt = 0;
    acc = '0;
    phase = PH_NSPACE;
  endfunction

  function automatic void flag_error(status_t s);
    line_st = s;
    phase = PH_IGNORE;
  endfunction

  function automatic void store_number();
    logic [63:0] v;
    v = neg ? (64'd0 - acc) : acc;
    vals[sel] = value_t'(v[VALUE_WIDTH-1:0]);
  endfunction

  function automatic void push_digit(int d);
    if (!in_frac) begin
      acc = acc * 64'd10 + 64'(d) * decade(FRACTION_DIGITS);
    end else if (frac_cnt < FRACTION_DIGITS) begin
      acc = acc + 64'(d) * decade(FRACTION_DIGITS - 1 - frac_cnt);
      frac_cnt++;
    end
    if (acc > MAG_LIMIT) acc = MAG_LIMIT;
  endfunction

  function automatic void word_letter(char_t c);
    char_t u;
    u = (c >= CH_LO_A && c <= CH_LO_Z) ? char_t'(c - CH_CASE) : c;
    case (u)
      CH_G: flag_error(ST_G_ERR);
      CH_X: begin_number(AX_X);
      CH_Y: begin_number(AX_Y);
      CH_Z: begin_number(AX_Z);
      CH_F: begin_number(AX_F);
      default: ;
    endcase
  endfunction

  function automatic void parse_char(char_t c);
    logic digit;
    digit = (c >= CH_0 && c <= CH_9);
    case (phase)
      PH_START: begin
        line_st = ST_OK;
        if (c == CH_LPAREN) begin
          phase = PH_IGNORE;
        end else if (c != CH_SPACE) begin
          phase = PH_MAIN;
          if (c == CH_G || c == char_t'(CH_G + CH_CASE)) phase = PH_G9;
          else word_letter(c);
        end
      end
      PH_MAIN: word_letter(c);
      PH_G9: begin
        if (c == CH_9) phase = PH_G0;
        else flag_error(ST_G_ERR);
      end
      PH_G0: begin
        if (c == CH_0) begin
          mode = 1'b1;
          phase = PH_MAIN;
        end else begin
          flag_error(ST_G_ERR);
        end
      end
      PH_NSPACE, PH_NFIRST: begin
        if (phase == PH_NSPACE && c == CH_SPACE) begin
        end else if (phase == PH_NSPACE && c == CH_MINUS) begin
          neg = 1'b1;
          phase = PH_NFIRST;
        end else if (digit) begin
          push_digit(int'(c - CH_0));
          phase = PH_NDIGITS;
        end else begin
          flag_error(status_t'(ST_X_ERR + sel));
        end
      end
      PH_NDIGITS: begin
        if (digit) begin
          push_digit(int'(c - CH_0));
        end else if (c == CH_DOT) begin
          in_frac = 1'b1;
        end else begin
          store_number();
          phase = PH_MAIN;
          word_letter(c);
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void close_line();
    if (phase == PH_START) line_st = ST_OK;
    else if (phase == PH_NSPACE || phase == PH_NFIRST || phase == PH_NDIGITS) store_number();
    else if (phase == PH_G9 || phase == PH_G0) line_st = ST_G_ERR;
    phase = PH_START;
    neg = 1'b0;
    in_frac = 1'b0;
    frac_cnt = 0;
    acc = '0;
  endfunction

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    $display("%0t: line result %s: got %h, expected %h", $time, field, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      parser_reset();
      line_results_due.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (line_results_due.size() == 0) begin
          report_mismatch("with no line pending", 32'(out_tdata[OUT_ST_LSB +: 3]), '0);
        end else begin
          want_res = line_results_due.pop_front();
          if (out_tdata[OUT_ST_LSB +: 3] != want_res.st)
            report_mismatch("status", 32'(out_tdata[OUT_ST_LSB +: 3]), 32'(want_res.st));
          if (out_tdata[OUT_MODE_BIT] != want_res.mode)
            report_mismatch("mode", 32'(out_tdata[OUT_MODE_BIT]), 32'(want_res.mode));
          if (out_tdata[OUT_VAL_LSB +: VALUE_WIDTH] != want_res.x)
            report_mismatch("x", out_tdata[OUT_VAL_LSB +: VALUE_WIDTH], want_res.x);
          if (out_tdata[OUT_VAL_LSB + VALUE_WIDTH +: VALUE_WIDTH] != want_res.y)
            report_mismatch("y", out_tdata[OUT_VAL_LSB + VALUE_WIDTH +: VALUE_WIDTH],
                            want_res.y);
          if (out_tdata[OUT_VAL_LSB + 2 * VALUE_WIDTH +: VALUE_WIDTH] != want_res.z)
            report_mismatch("z", out_tdata[OUT_VAL_LSB + 2 * VALUE_WIDTH +: VALUE_WIDTH],
                            want_res.z);
          if (out_tdata[OUT_VAL_LSB + 3 * VALUE_WIDTH +: VALUE_WIDTH] != want_res.feed)
            report_mismatch("feed", out_tdata[OUT_VAL_LSB + 3 * VALUE_WIDTH +: VALUE_WIDTH],
                            want_res.feed);
        end
      end
      if (in_tvalid && in_tready) begin
        if (in_tuser) begin
          parser_reset();
        end else begin
          parse_char(in_tdata);
          if (in_tlast || in_tdata == CH_NUL) begin
            close_line();
            line_results_due.push_back('{st: line_st, mode: mode, x: vals[AX_X],
                                         y: vals[AX_Y], z: vals[AX_Z], feed: vals[AX_F]});
          end
        end
      end
    end
    lines_due = line_results_due.size();
  end

endmodule

/* tb/gcode_line_word_parser_tb.sv */
`timescale 1ns / 100ps
// testbench top for the g-code line word parser: stimulus, handshake idling and verdict
module gcode_line_word_parser_tb;
  import glp_pkg::*;

  localparam logic CMD_CHAR  = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;
  localparam int   TOTAL_ITEMS = 1250;
  localparam int   QUIET_LIMIT = 1000;

  logic             clk;
  logic             rst_n;
  logic             in_tvalid;
  logic             in_tready;
  char_t            in_tdata;   // [7:0] char_code
  logic             in_tuser;   // [0] command
  logic             in_tlast;
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;  // status, mode_code, x, y, z, feed_value, zero pad

  int    lines_due;
  int    mismatches;
  int    sent = 0;
  int    quiet = 0;
  int    stall_left = 0;
  logic  idle_on = 1'b1;
  char_t line_chars[$];

  gcode_line_word_parser dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  gcode_line_word_parser_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .lines_due  (lines_due),
    .mismatches (mismatches)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    if (stall_left != 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      out_tready <= 1'b0;
      stall_left <= $urandom_range(0, 16);
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  task automatic send_item(logic cmd, char_t ch, logic last);
    logic took;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= ch;
    in_tlast  <= last;
    do begin
      @(negedge clk);
      took = in_tready;
      @(posedge clk);
    end while (!took);
    sent++;
  endtask

  task automatic send_line(logic nul_end);
    logic use_nul;
    use_nul = nul_end || line_chars.size() == 0;
    foreach (line_chars[i])
      send_item(CMD_CHAR, line_chars[i], !use_nul && i == line_chars.size() - 1);
    if (use_nul) send_item(CMD_CHAR, CH_NUL, 1'($urandom_range(0, 1)));
  endtask

  function automatic void load_str(string s);
    line_chars.delete();
    for (int i = 0; i < s.len(); i++) line_chars.push_back(char_t'(s[i]));
  endfunction

  function automatic char_t any_case(char_t u);
    return $urandom_range(0, 1) ? char_t'(u + CH_CASE) : u;
  endfunction

  function automatic char_t rand_digit();
    return char_t'(CH_0 + $urandom_range(0, 9));
  endfunction

  function automatic void build_line();
    int    kind;
    int    nwords;
    char_t letters[4];
    letters = '{CH_X, CH_Y, CH_Z, CH_F};
    line_chars.delete();
    kind = $urandom_range(0, 99);
    if (kind < 12) begin
      repeat ($urandom_range(1, 10)) line_chars.push_back(char_t'($urandom_range(0, 255)));
      return;
    end
    if ($urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 3)) line_chars.push_back(CH_SPACE);
    if (kind < 20) begin
      if (kind < 16) begin
        line_chars.push_back(CH_LPAREN);
        repeat ($urandom_range(0, 6)) line_chars.push_back(char_t'($urandom_range(32, 126)));
      end
      return;
    end
    if (kind < 45) begin
      line_chars.push_back(any_case(CH_G));
      if ($urandom_range(0, 9) == 0) begin
        line_chars.push_back(char_t'($urandom_range(32, 126)));
      end else begin
        line_chars.push_back(CH_9);
        if ($urandom_range(0, 9) == 0) line_chars.push_back(char_t'($urandom_range(32, 126)));
        else line_chars.push_back(CH_0);
      end
      if ($urandom_range(0, 3) == 0) line_chars.push_back(CH_SPACE);
      if ($urandom_range(0, 5) == 0) line_chars.push_back(char_t'($urandom_range(33, 64)));
    end
    nwords = $urandom_range(0, 4);
    for (int w = 0; w < nwords; w++) begin
      if ($urandom_range(0, 29) == 0) line_chars.push_back(any_case(CH_G));
      line_chars.push_back(any_case(letters[$urandom_range(0, 3)]));
      if (w == nwords - 1 && $urandom_range(0, 9) == 0) return;
      if ($urandom_range(0, 3) == 0)
        repeat ($urandom_range(1, 2)) line_chars.push_back(CH_SPACE);
      if ($urandom_range(0, 1)) line_chars.push_back(CH_MINUS);
      if ($urandom_range(0, 19) == 0) begin
        case ($urandom_range(0, 2))
          0: line_chars.push_back(CH_DOT);
          1: line_chars.push_back(CH_SPACE);
          default: line_chars.push_back(char_t'($urandom_range(32, 126)));
        endcase
      end
      repeat (($urandom_range(0, 7) == 0) ? $urandom_range(5, 11) : $urandom_range(1, 4))
        line_chars.push_back(rand_digit());
      if ($urandom_range(0, 1)) begin
        line_chars.push_back(CH_DOT);
        repeat ($urandom_range(0, 6)) line_chars.push_back(rand_digit());
        if ($urandom_range(0, 9) == 0) begin
          line_chars.push_back(CH_DOT);
          line_chars.push_back(rand_digit());
        end
      end
      if ($urandom_range(0, 2) == 0) line_chars.push_back(CH_SPACE);
    end
  endfunction

  initial begin
    logic drained;
    drained = 1'b0;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= CH_NUL;
    in_tuser  <= CMD_CHAR;
    in_tlast  <= 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed lines
    send_item(CMD_CLEAR, 8'hFF, 1'b1);
    load_str("");
    send_line(1'b1);
    load_str("(x");
    send_line(1'b0);
    load_str("g90Z-1.23456");
    send_line(1'b0);
    load_str("x");
    send_line(1'b0);
    load_str("Y");
    send_line(1'b1);
    load_str("G1");
    send_line(1'b0);
    load_str("F99999999");
    send_line(1'b0);
    load_str(" X1Y.5");
    send_line(1'b0);
    line_chars = '{CH_SPACE, 8'hFF};
    send_line(1'b0);

    // random lines
    while (sent < TOTAL_ITEMS) begin
      idle_on <= (sent < TOTAL_ITEMS - 200) && ((sent / 150) % 3 != 2);
      if (!drained && sent >= TOTAL_ITEMS / 2) begin
        drained = 1'b1;
        in_tvalid <= 1'b0;
        while (lines_due != 0) @(negedge clk);
        @(posedge clk);
      end
      if ($urandom_range(0, 19) == 0) begin
        send_item(CMD_CLEAR, char_t'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end else begin
        build_line();
        send_line($urandom_range(0, 7) == 0);
      end
    end

    in_tvalid <= 1'b0;
    idle_on <= 1'b0;
    while (lines_due != 0) @(negedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl/core
rtl/core/glp_pkg.sv
rtl/core/glp_step.sv
rtl/core/gcode_line_word_parser.sv
rtl/core/glp_checker.sv
tb/gcode_line_word_parser_checker.sv
tb/gcode_line_word_parser_tb.sv
